// ===== src/msseq_pkg.sv =====
// Shared types, constants and helpers for the motor start-up sequencer.
// Used by msseq_csr, msseq_core and motor_startup_sequencer_unit.
package msseq_pkg;

   // Width of the phase tick counter; it wraps at this width.
   localparam int COUNT_BITS = 20;
   // Width of the tick limit registers.
   localparam int LIMIT_BITS = 20;
   // Width used when comparing the counter with a limit.
   localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam int CSR_DATA_BITS = 20;
   localparam int CSR_ADDR_BITS = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_BITS-1:0] REG_ALIGN_ID      = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ALIGN_STEP    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ALIGN_TICKS   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OPEN_IQ       = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OPEN_STEP     = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OPEN_TICKS    = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] REG_IQ_MIN        = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] REG_IQ_MAX        = 3'd7;

   // Phase codes as they appear on the result.
   localparam logic [1:0] PHASE_CODE_STOP   = 2'd0;
   localparam logic [1:0] PHASE_CODE_ALIGN  = 2'd1;
   localparam logic [1:0] PHASE_CODE_OPEN   = 2'd2;
   localparam logic [1:0] PHASE_CODE_CLOSED = 2'd3;

   // Internal sequencer state, one-hot.
   typedef enum logic [3:0] {
      PH_STOP   = 4'b0001,
      PH_ALIGN  = 4'b0010,
      PH_OPEN   = 4'b0100,
      PH_CLOSED = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                  run;
      logic                  dir;
      logic signed [15:0]    iq_request;
      logic [15:0]           hall_inc;
      logic                  hall_load;
      logic [15:0]           hall_angle;
   } req_type;

   typedef struct packed {
      logic                  foc_enable;
      logic signed [15:0]    id_ref;
      logic signed [15:0]    iq_ref;
      logic [15:0]           theta;
      logic                  clear_current_int;
      logic                  clear_speed_int;
      logic                  speed_loop_on;
      logic [1:0]            phase;
   } rsp_type;

   // Configuration registers as seen by the sequencer core.
   typedef struct packed {
      logic signed [15:0]    align_id;
      logic [15:0]           align_step;
      logic [LIMIT_BITS-1:0] align_ticks;
      logic signed [15:0]    open_iq;
      logic [15:0]           open_step;
      logic [LIMIT_BITS-1:0] open_ticks;
      logic signed [15:0]    iq_min;
      logic signed [15:0]    iq_max;
   } cfg_type;

   // Advance an angle by one step; the wrap at a full turn is modulo 2^16.
   function automatic logic [15:0] turn(input logic [15:0] angle,
                                        input logic [15:0] step,
                                        input logic ccw);
      return ccw ? (angle - step) : (angle + step);
   endfunction

endpackage

// ===== src/msseq_csr.sv =====
// Configuration register file of the motor start-up sequencer.
// Depends on msseq_pkg for the register indexes and cfg_type.
module msseq_csr
   import msseq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_ALIGN_ID:      cfg_in.align_id      = csr_wdata[15:0];
            REG_ALIGN_STEP:    cfg_in.align_step    = csr_wdata[15:0];
            REG_ALIGN_TICKS:   cfg_in.align_ticks   = csr_wdata[LIMIT_BITS-1:0];
            REG_OPEN_IQ:       cfg_in.open_iq       = csr_wdata[15:0];
            REG_OPEN_STEP:     cfg_in.open_step     = csr_wdata[15:0];
            REG_OPEN_TICKS:    cfg_in.open_ticks    = csr_wdata[LIMIT_BITS-1:0];
            REG_IQ_MIN:        cfg_in.iq_min        = csr_wdata[15:0];
            REG_IQ_MAX:        cfg_in.iq_max        = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers come out of reset with their documented defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.align_id      <= 16'sd4096;
         cfg_ff.align_step    <= 16'd13;
         cfg_ff.align_ticks   <= LIMIT_BITS'(5000);
         cfg_ff.open_iq       <= 16'sd6144;
         cfg_ff.open_step     <= 16'd104;
         cfg_ff.open_ticks    <= LIMIT_BITS'(5000);
         cfg_ff.iq_min        <= 16'sd3277;
         cfg_ff.iq_max        <= 16'sd14336;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/msseq_core.sv =====
// Sequencer state and per-tick update logic of the motor start-up sequencer.
// Depends on msseq_pkg for the phase encoding, payload structs and turn().
module msseq_core
   import msseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  tick_ff, tick_in;
   logic [15:0]            ramp_ff, ramp_in;
   logic [15:0]            hall_ff, hall_in;
   logic                   spd_en_ff, spd_en_in;

   logic [COUNT_BITS-1:0]  tick_inc;
   logic [15:0]            hall_base;
   logic [15:0]            align_angle;
   logic [15:0]            open_angle;
   logic                   align_done;
   logic                   open_done;
   logic signed [15:0]     iq_clamped;

   // Shared terms of the tick update.
   always_comb begin
      tick_inc    = tick_ff + 1'b1;
      hall_base   = item.hall_load ? item.hall_angle : hall_ff;
      align_angle = turn(ramp_ff, cfg.align_step, item.dir);
      open_angle  = turn(ramp_ff, cfg.open_step, item.dir);
      align_done  = CMP_BITS'(tick_inc) >= CMP_BITS'(cfg.align_ticks);
      open_done   = CMP_BITS'(tick_inc) >= CMP_BITS'(cfg.open_ticks);
      if (item.iq_request < cfg.iq_min) begin
         iq_clamped = cfg.iq_min;
      end else if (item.iq_request > cfg.iq_max) begin
         iq_clamped = cfg.iq_max;
      end else begin
         iq_clamped = item.iq_request;
      end
   end

   // Next state and result for the transaction being processed.
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      ramp_in   = ramp_ff;
      hall_in   = hall_base;
      spd_en_in = spd_en_ff;
      result    = '0;

      if (!item.run || phase_ff == PH_STOP) begin
         // Stop tick: outputs quiet, counter and speed loop cleared.
         tick_in   = '0;
         spd_en_in = 1'b0;
         phase_in  = item.run ? PH_ALIGN : PH_STOP;
         result.phase = PHASE_CODE_STOP;
      end else begin
         result.foc_enable = 1'b1;
         case (phase_ff)
            PH_ALIGN: begin
               result.id_ref = cfg.align_id;
               result.theta  = align_angle;
               result.phase  = PHASE_CODE_ALIGN;
               spd_en_in     = 1'b0;
               ramp_in       = align_angle;
               tick_in       = tick_inc;
               if (align_done) begin
                  result.clear_current_int = 1'b1;
                  ramp_in  = '0;
                  tick_in  = '0;
                  phase_in = PH_OPEN;
               end
            end
            PH_OPEN: begin
               result.iq_ref = cfg.open_iq;
               result.theta  = open_angle;
               result.phase  = PHASE_CODE_OPEN;
               ramp_in       = open_angle;
               tick_in       = tick_inc;
               if (open_done) begin
                  result.clear_current_int = 1'b1;
                  result.clear_speed_int   = 1'b1;
                  spd_en_in = 1'b1;
                  phase_in  = PH_CLOSED;
               end
            end
            default: begin
               // Closed loop: Hall angle tracking, clamped speed-loop demand.
               hall_in       = turn(hall_base, item.hall_inc, item.dir);
               result.theta  = hall_in;
               result.iq_ref = iq_clamped;
               result.phase  = PHASE_CODE_CLOSED;
            end
         endcase
      end
      result.speed_loop_on = spd_en_in;
   end

   // State advances once per processed transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STOP;
         tick_ff   <= '0;
         ramp_ff   <= '0;
         hall_ff   <= '0;
         spd_en_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         ramp_ff   <= ramp_in;
         hall_ff   <= hall_in;
         spd_en_ff <= spd_en_in;
      end
   end

endmodule

// ===== src/motor_startup_sequencer_unit.sv =====
// Top level of the motor start-up sequencer: input register, core, result register.
// Depends on msseq_pkg, msseq_csr and msseq_core.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//   csr      in         csr_we                csr_addr, csr_wdata
//
// A transaction is registered on entry in the input register and its result is
// registered in the result register once that one is free; one transaction per cycle
// is sustained while rsp_ready stays high.
// The core's state update is combinational between the input and result registers.
// Reset brings the CSRs to their defaults, clears both valid flags and sets the phase to stop.
// When the result register is held, the input register fills and then req_ready drops.
module motor_startup_sequencer_unit
   import msseq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   req_type in_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   msseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msseq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The input register moves into the result register when that one is free.
   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_enable_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_ff.foc_enable == (out_ff.phase != PHASE_CODE_STOP)))
      else $error("foc_enable disagrees with the reported phase");

   a_handover_strobes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.clear_speed_int) |->
         (out_ff.clear_current_int && out_ff.speed_loop_on
          && out_ff.phase == PHASE_CODE_OPEN))
      else $error("closed-loop handover strobes inconsistent");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while a stage was free");

   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a processed transaction");
`endif

endmodule

// ===== sim/tb_motor_startup_sequencer_unit.sv =====
// Self-checking testbench for motor_startup_sequencer_unit: directed and random control ticks.
// A built-in model predicts each result transaction unless a directed row gives its own.
// Depends on msseq_pkg and the RTL of the sequencer.
module tb_motor_startup_sequencer_unit;
   import msseq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_TICKS = 400;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum bit { ROW_TICK, ROW_WRITE } row_kind_type;

   // One line of the directed stimulus: a tick or a register write.
   typedef struct {
      row_kind_type                kind;
      req_type                     req;
      bit                          typed;
      rsp_type                     typed_rsp;
      logic [CSR_ADDR_BITS-1:0]    addr;
      logic [CSR_DATA_BITS-1:0]    wdata;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Copy of the sequencer state and its registers, kept in step with accepted ticks.
   cfg_type                  settings;
   phase_type                seq_phase;
   logic [COUNT_BITS-1:0]    tick_count;
   logic [15:0]              ramp_angle;
   logic [15:0]              hall_acc;
   logic                     speed_on;

   rsp_type                  tick_results_due[$];
   stim_row_type             directed_rows[$];

   int                       mismatch_count = 0;
   int                       results_checked = 0;
   int                       ticks_sent = 0;
   int                       closed_ticks = 0;
   int                       writes_done = 0;
   int                       cycles_run = 0;
   bit                       sender_calm = 1'b0;

   motor_startup_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #6ns clock = ~clock;

   // The run is cut off once it reaches the cycle limit.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles, %0d results outstanding", $time,
                  cycles_run, tick_results_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Predict the result of one control tick and advance the sequencer state.
   function automatic rsp_type sequencer_tick(input req_type r);
      rsp_type o;
      o = '0;
      o.phase = PHASE_CODE_STOP;
      if (r.hall_load) begin
         hall_acc = r.hall_angle;
      end
      if (!r.run || seq_phase == PH_STOP) begin
         // A stop tick; with run high it also requests the start.
         tick_count = '0;
         speed_on   = 1'b0;
         seq_phase  = r.run ? PH_ALIGN : PH_STOP;
      end else if (seq_phase == PH_ALIGN) begin
         o.foc_enable = 1'b1;
         o.id_ref     = settings.align_id;
         o.phase      = PHASE_CODE_ALIGN;
         speed_on     = 1'b0;
         ramp_angle   = r.dir ? ramp_angle - settings.align_step
                              : ramp_angle + settings.align_step;
         o.theta      = ramp_angle;
         tick_count   = tick_count + 1'b1;
         if (tick_count >= settings.align_ticks) begin
            o.clear_current_int = 1'b1;
            ramp_angle = '0;
            tick_count = '0;
            seq_phase  = PH_OPEN;
         end
      end else if (seq_phase == PH_OPEN) begin
         o.foc_enable = 1'b1;
         o.iq_ref     = settings.open_iq;
         o.phase      = PHASE_CODE_OPEN;
         tick_count   = tick_count + 1'b1;
         ramp_angle   = r.dir ? ramp_angle - settings.open_step
                              : ramp_angle + settings.open_step;
         o.theta      = ramp_angle;
         if (tick_count >= settings.open_ticks) begin
            o.clear_current_int = 1'b1;
            o.clear_speed_int   = 1'b1;
            speed_on  = 1'b1;
            seq_phase = PH_CLOSED;
         end
      end else begin
         // Closed loop: angle from the Hall estimate, q current clamped.
         o.foc_enable = 1'b1;
         o.phase      = PHASE_CODE_CLOSED;
         hall_acc     = r.dir ? hall_acc - r.hall_inc : hall_acc + r.hall_inc;
         o.theta      = hall_acc;
         if ($signed(r.iq_request) < $signed(settings.iq_min)) begin
            o.iq_ref = settings.iq_min;
         end else if ($signed(r.iq_request) > $signed(settings.iq_max)) begin
            o.iq_ref = settings.iq_max;
         end else begin
            o.iq_ref = r.iq_request;
         end
      end
      o.speed_loop_on = speed_on;
      return o;
   endfunction

   // Random 16-bit value with the extremes drawn often.
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Tick limit, mostly short so that a sequence reaches closed loop.
   function automatic logic [LIMIT_BITS-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return LIMIT_BITS'($urandom_range(0, 20'hFFFFF));
         default: return LIMIT_BITS'($urandom_range(1, 9));
      endcase
   endfunction

   function automatic req_type mk_req(input bit run, input bit dir, input logic [15:0] iq,
                                      input logic [15:0] inc, input bit load,
                                      input logic [15:0] angle);
      req_type r;
      r.run        = run;
      r.dir        = dir;
      r.iq_request = iq;
      r.hall_inc   = inc;
      r.hall_load  = load;
      r.hall_angle = angle;
      return r;
   endfunction

   function automatic stim_row_type tick_row(input req_type r);
      stim_row_type row;
      row = '{kind: ROW_TICK, req: r, typed: 1'b0, typed_rsp: '0, addr: '0, wdata: '0};
      return row;
   endfunction

   function automatic stim_row_type typed_row(input req_type r, input rsp_type e);
      stim_row_type row;
      row = '{kind: ROW_TICK, req: r, typed: 1'b1, typed_rsp: e, addr: '0, wdata: '0};
      return row;
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_ADDR_BITS-1:0] addr,
                                              input logic [CSR_DATA_BITS-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_WRITE, req: '0, typed: 1'b0, typed_rsp: '0, addr: addr, wdata: data};
      return row;
   endfunction

   // Register write; the caller lowers csr_we after the last write of a batch.
   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      case (addr)
         REG_ALIGN_ID:      settings.align_id      = data[15:0];
         REG_ALIGN_STEP:    settings.align_step    = data[15:0];
         REG_ALIGN_TICKS:   settings.align_ticks   = data[LIMIT_BITS-1:0];
         REG_OPEN_IQ:       settings.open_iq       = data[15:0];
         REG_OPEN_STEP:     settings.open_step     = data[15:0];
         REG_OPEN_TICKS:    settings.open_ticks    = data[LIMIT_BITS-1:0];
         REG_IQ_MIN:        settings.iq_min        = data[15:0];
         REG_IQ_MAX:        settings.iq_max        = data[15:0];
         default: ;
      endcase
      writes_done++;
   endtask

   // Offer one tick transaction and record its expected result on acceptance.
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = sequencer_tick(r);
      tick_results_due.push_back(typed ? typed_rsp : predicted);
      ticks_sent++;
      if (predicted.phase == PHASE_CODE_CLOSED) begin
         closed_ticks++;
      end
   endtask

   // Hold off the sender until every outstanding result is back and the pipe is empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic flag_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: random stalls, with calm stretches, and field-by-field checks.
   initial begin
      int      stall;
      int      burst_left;
      bit      calm;
      rsp_type want;
      burst_left = 0;
      calm = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(10, 40);
            calm = ($urandom_range(0, 2) == 0);
         end
         burst_left--;
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (tick_results_due.size() == 0) begin
            $display("%0t ns: result transaction with nothing expected, actual %h", $time,
                     rsp_data);
            mismatch_count++;
         end else begin
            want = tick_results_due.pop_front();
            results_checked++;
            flag_field("foc_enable", 16'(want.foc_enable), 16'(rsp_data.foc_enable));
            flag_field("id_ref", want.id_ref, rsp_data.id_ref);
            flag_field("iq_ref", want.iq_ref, rsp_data.iq_ref);
            flag_field("theta", want.theta, rsp_data.theta);
            flag_field("clear_current_int", 16'(want.clear_current_int),
                       16'(rsp_data.clear_current_int));
            flag_field("clear_speed_int", 16'(want.clear_speed_int),
                       16'(rsp_data.clear_speed_int));
            flag_field("speed_loop_on", 16'(want.speed_loop_on), 16'(rsp_data.speed_loop_on));
            flag_field("phase", 16'(want.phase), 16'(rsp_data.phase));
         end
      end
   end

   // Stimulus: reset, directed rows, then random start-up sequences.
   initial begin
      rsp_type     stop_rsp;
      rsp_type     align_rsp;
      req_type     r;
      bit          writing;
      bit          dir;
      bit          noisy;
      int          len;
      logic [15:0] lo_bound;
      logic [15:0] hi_bound;
      logic [15:0] swap;

      settings = '{align_id: 16'sd4096, align_step: 16'd13, align_ticks: 20'd5000,
                   open_iq: 16'sd6144, open_step: 16'd104, open_ticks: 20'd5000,
                   iq_min: 16'sd3277, iq_max: 16'sd14336};
      seq_phase  = PH_STOP;
      tick_count = '0;
      ramp_angle = '0;
      hall_acc   = '0;
      speed_on   = 1'b0;

      stop_rsp = '0;
      stop_rsp.phase = PHASE_CODE_STOP;
      align_rsp = '0;
      align_rsp.foc_enable = 1'b1;
      align_rsp.id_ref = 16'sd4096;
      align_rsp.theta = 16'd13;
      align_rsp.phase = PHASE_CODE_ALIGN;

      // Reset values: stop, start request, first alignment ticks, stop again.
      directed_rows.push_back(typed_row(mk_req(0, 1, 16'h8000, 16'hFFFF, 1, 16'hFFFF),
                                        stop_rsp));
      directed_rows.push_back(typed_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000),
                                        stop_rsp));
      directed_rows.push_back(typed_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000),
                                        align_rsp));
      directed_rows.push_back(tick_row(mk_req(1, 1, 16'h7FFF, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(typed_row(mk_req(0, 0, 16'h0000, 16'h0000, 0, 16'h0000),
                                        stop_rsp));
      // Extreme registers and zero tick limits: each phase lasts a single tick.
      directed_rows.push_back(write_row(REG_ALIGN_ID, 16'h8000));
      directed_rows.push_back(write_row(REG_ALIGN_STEP, 16'hFFFF));
      directed_rows.push_back(write_row(REG_ALIGN_TICKS, 20'h00000));
      directed_rows.push_back(write_row(REG_OPEN_IQ, 16'h7FFF));
      directed_rows.push_back(write_row(REG_OPEN_STEP, 16'h0000));
      directed_rows.push_back(write_row(REG_OPEN_TICKS, 20'h00000));
      directed_rows.push_back(write_row(REG_IQ_MIN, 16'h8000));
      directed_rows.push_back(write_row(REG_IQ_MAX, 16'h7FFF));
      directed_rows.push_back(typed_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000),
                                        stop_rsp));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 1, 16'h8000, 16'hFFFF, 1, 16'h1234)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h7FFF, 16'h8000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0001, 0, 16'hFFFF)));
      // Clamp bounds crossed: minimum above maximum.
      directed_rows.push_back(write_row(REG_IQ_MIN, 16'h0064));
      directed_rows.push_back(write_row(REG_IQ_MAX, 16'hFF9C));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0010, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 1, 16'h00C8, 16'h0010, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h8000, 16'h0010, 1, 16'h8000)));
      directed_rows.push_back(typed_row(mk_req(0, 0, 16'h7FFF, 16'h0000, 0, 16'h0000),
                                        stop_rsp));
      // Largest tick limits: alignment never finishes within the run.
      directed_rows.push_back(write_row(REG_ALIGN_TICKS, 20'hFFFFF));
      directed_rows.push_back(write_row(REG_OPEN_TICKS, 20'hFFFFF));
      directed_rows.push_back(write_row(REG_ALIGN_STEP, 16'h5555));
      directed_rows.push_back(write_row(REG_ALIGN_ID, 16'h7FFF));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 1, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(tick_row(mk_req(1, 0, 16'h0000, 16'h0000, 0, 16'h0000)));
      directed_rows.push_back(typed_row(mk_req(0, 1, 16'h0000, 16'h0000, 0, 16'h0000),
                                        stop_rsp));
      // A full short sequence into closed loop with a clamp window around zero.
      directed_rows.push_back(write_row(REG_ALIGN_TICKS, 20'd2));
      directed_rows.push_back(write_row(REG_OPEN_TICKS, 20'd3));
      directed_rows.push_back(write_row(REG_OPEN_STEP, 16'h8000));
      directed_rows.push_back(write_row(REG_IQ_MIN, 16'hF000));
      directed_rows.push_back(write_row(REG_IQ_MAX, 16'h1000));
      for (int k = 0; k < 7; k++) begin
         directed_rows.push_back(tick_row(mk_req(1, 0, 16'h7FFF, 16'h0400, 0, 16'h0000)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (!writing) begin
               drain_results();
               writing = 1'b1;
            end
            write_reg(directed_rows[i].addr, directed_rows[i].wdata);
         end else begin
            if (writing) begin
               csr_we  <= 1'b0;
               writing = 1'b0;
            end
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_rsp);
         end
      end

      // Random start-up sequences, most of them well formed, some with run dropping out.
      len = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < len) begin
         if ($urandom_range(0, 2) != 0) begin
            drain_results();
            lo_bound = pick16();
            hi_bound = pick16();
            if ($urandom_range(0, 3) != 0 && $signed(lo_bound) > $signed(hi_bound)) begin
               swap     = lo_bound;
               lo_bound = hi_bound;
               hi_bound = swap;
            end
            write_reg(REG_IQ_MIN, lo_bound);
            write_reg(REG_IQ_MAX, hi_bound);
            write_reg(REG_ALIGN_ID, pick16());
            write_reg(REG_OPEN_IQ, pick16());
            write_reg(REG_ALIGN_STEP, pick16());
            write_reg(REG_OPEN_STEP, pick16());
            write_reg(REG_ALIGN_TICKS, pick_limit());
            write_reg(REG_OPEN_TICKS, pick_limit());
            csr_we <= 1'b0;
         end
         sender_calm = ($urandom_range(0, 3) == 0);
         dir   = 1'($urandom_range(0, 1));
         noisy = ($urandom_range(0, 7) == 0);
         begin
            int seq_len;
            int k;
            if (settings.align_ticks > 40 || settings.open_ticks > 40) begin
               seq_len = 40;
            end else begin
               seq_len = int'(settings.align_ticks) + int'(settings.open_ticks) + 2 +
                         $urandom_range(0, 20);
               if (seq_len > 40) seq_len = 40;
            end
            for (k = 0; k < seq_len; k++) begin
               if ($urandom_range(0, 9) == 0) dir = ~dir;
               r.run = (k == 0) ? 1'b0
                     : (noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) != 0));
               r.dir = dir;
               case ($urandom_range(0, 5))
                  0: r.iq_request = settings.iq_min + 16'($urandom_range(0, 2)) - 16'd1;
                  1: r.iq_request = settings.iq_max + 16'($urandom_range(0, 2)) - 16'd1;
                  default: r.iq_request = pick16();
               endcase
               r.hall_inc   = pick16();
               r.hall_load  = ($urandom_range(0, 4) == 0);
               r.hall_angle = pick16();
               send_item(r, 1'b0, stop_rsp);
            end
         end
      end

      // Wind down: no more ticks, wait for the last results and a little beyond.
      req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sequenced %0d ticks, %0d of them in closed loop, with %0d register writes.",
               ticks_sent, closed_ticks, writes_done);
      $display("Compared %0d results field by field; %0d mismatches.", results_checked,
               mismatch_count);
      if (mismatch_count == 0 && tick_results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
